// File: sv/pbfm_pkg.sv
`default_nettype none
package pbfm_pkg;
    localparam int POOL_FRAMES = 16;
    localparam int PAGE_BITS = 31;
    localparam int PIN_BITS = 16;
    localparam int FRAME_BITS = $clog2(POOL_FRAMES);
    localparam int CNT_BITS = $clog2(POOL_FRAMES + 1);

    localparam logic [2:0] KIND_FETCH = 3'd0;
    localparam logic [2:0] KIND_NEW = 3'd1;
    localparam logic [2:0] KIND_UNPIN = 3'd2;
    localparam logic [2:0] KIND_DELETE = 3'd3;
    localparam logic [2:0] KIND_FLUSH = 3'd4;
    localparam logic [2:0] KIND_FLUSH_ALL = 3'd5;

    localparam logic [1:0] CMD_RESP = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NOT_RES = 2'd1;
    localparam logic [1:0] ST_NO_FREE = 2'd2;
    localparam logic [1:0] ST_PINNED = 2'd3;

    localparam logic REG_COUNT = 1'b0;
    localparam logic REG_NUMBER = 1'b1;

    // datapath operations requested by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_SCAN_STEP,
        OP_LRU_REMOVE,
        OP_LRU_APPEND,
        OP_POP_FREE,
        OP_POP_LRU,
        OP_INSTALL,
        OP_PIN_INC,
        OP_UNPIN,
        OP_DELETE,
        OP_CLEAN
    } dp_op_t;

    typedef struct packed {
        dp_op_t                  op;
        logic [FRAME_BITS-1:0]   frame;
        logic [PAGE_BITS-1:0]    page;
        logic                    dirty;
        logic                    scan_clear;
        logic                    alloc_step;
    } dp_cmd_t;

    typedef struct packed {
        logic                    scan_done;
        logic                    scan_hit;
        logic [FRAME_BITS-1:0]   scan_frame;
        logic [FRAME_BITS-1:0]   lru_pos;
        logic                    lru_found;
        logic [CNT_BITS-1:0]     free_depth;
        logic [CNT_BITS-1:0]     lru_length;
        logic [FRAME_BITS-1:0]   free_top;
        logic [FRAME_BITS-1:0]   lru_head;
        logic                    f_in_use;
        logic                    f_modified;
        logic [PAGE_BITS-1:0]    f_page;
        logic [PIN_BITS-1:0]     f_pins;
        logic [PAGE_BITS-1:0]    alloc;
    } dp_status_t;

    typedef struct packed {
        logic [1:0]              command;
        logic [PAGE_BITS-1:0]    result_page;
        logic [FRAME_BITS-1:0]   frame_index;
        logic [1:0]              status;
        logic                    last_item;
    } result_t;
endpackage
`default_nettype wire

// File: sv/pbfm_datapath.sv
`default_nettype none
module pbfm_datapath import pbfm_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire dp_cmd_t    cmd,
    input  wire logic       cfg_we,
    input  wire logic       cfg_sel,
    input  wire logic [15:0] cfg_data,
    output dp_status_t      stat
);
    logic [POOL_FRAMES-1:0]   in_use_reg;
    logic [POOL_FRAMES-1:0]   modified_reg;
    logic [PIN_BITS-1:0]      pins_reg [POOL_FRAMES];
    logic [PAGE_BITS-1:0]     page_reg [POOL_FRAMES];
    logic [FRAME_BITS-1:0]    free_reg [POOL_FRAMES];
    logic [FRAME_BITS-1:0]    lru_reg  [POOL_FRAMES];
    logic [CNT_BITS-1:0]      free_depth_reg;
    logic [CNT_BITS-1:0]      lru_len_reg;
    logic [PAGE_BITS-1:0]     alloc_reg;
    logic [15:0]              icount_reg;
    // scan unit: walks one frame per cycle
    logic [CNT_BITS-1:0]      scan_idx_reg;
    logic                     scan_hit_reg;
    logic [FRAME_BITS-1:0]    scan_frame_reg;
    logic                     lru_found_reg;
    logic [FRAME_BITS-1:0]    lru_pos_reg;

    logic [FRAME_BITS-1:0] sidx;
    logic [FRAME_BITS-1:0] top_idx;
    logic [FRAME_BITS-1:0] last_lru;
    logic                  lru_rm;
    logic [PIN_BITS-1:0]   pin_dec;

    assign sidx = scan_idx_reg[FRAME_BITS-1:0];
    assign top_idx = FRAME_BITS'(free_depth_reg - CNT_BITS'(1));
    assign last_lru = FRAME_BITS'(lru_len_reg - CNT_BITS'(1));
    assign pin_dec = pins_reg[cmd.frame] - PIN_BITS'(1);
    assign lru_rm = (cmd.op == OP_LRU_REMOVE && lru_found_reg) || cmd.op == OP_POP_LRU;

    always_comb begin
        stat.scan_done  = (scan_idx_reg == CNT_BITS'(POOL_FRAMES));
        stat.scan_hit   = scan_hit_reg;
        stat.scan_frame = scan_frame_reg;
        stat.lru_found  = lru_found_reg;
        stat.lru_pos    = lru_pos_reg;
        stat.free_depth = free_depth_reg;
        stat.lru_length = lru_len_reg;
        stat.free_top   = free_reg[top_idx];
        stat.lru_head   = lru_reg[0];
        stat.f_in_use   = in_use_reg[cmd.frame];
        stat.f_modified = modified_reg[cmd.frame];
        stat.f_page     = page_reg[cmd.frame];
        stat.f_pins     = pins_reg[cmd.frame];
        stat.alloc      = alloc_reg;
    end

    // scan: page match on pool and position of frame in the LRU list
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.scan_clear) begin
            scan_idx_reg  <= '0;
            scan_hit_reg  <= 1'b0;
            lru_found_reg <= 1'b0;
            scan_frame_reg <= '0;
            lru_pos_reg <= '0;
        end else if (cmd.op == OP_SCAN_STEP && !stat.scan_done) begin
            scan_idx_reg <= scan_idx_reg + CNT_BITS'(1);
            if (!scan_hit_reg && in_use_reg[sidx] && page_reg[sidx] == cmd.page) begin
                scan_hit_reg   <= 1'b1;
                scan_frame_reg <= sidx;
            end
            if (!lru_found_reg && scan_idx_reg < lru_len_reg && lru_reg[sidx] == cmd.frame) begin
                lru_found_reg <= 1'b1;
                lru_pos_reg   <= sidx;
            end
        end
    end

    // LRU list: shift-left removal, tail append
    always_ff @(posedge aclk) begin
        for (int i = 0; i < POOL_FRAMES - 1; i++) begin
            if (lru_rm && (cmd.op == OP_POP_LRU || FRAME_BITS'(i) >= lru_pos_reg))
                lru_reg[i] <= lru_reg[i+1];
        end
        if (cmd.op == OP_LRU_APPEND && !lru_found_reg &&
            lru_len_reg < CNT_BITS'(POOL_FRAMES))
            lru_reg[lru_len_reg[FRAME_BITS-1:0]] <= cmd.frame;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lru_len_reg <= '0;
        end else if (lru_rm) begin
            lru_len_reg <= lru_len_reg - CNT_BITS'(1);
        end else if (cmd.op == OP_LRU_APPEND && !lru_found_reg &&
                     lru_len_reg < CNT_BITS'(POOL_FRAMES)) begin
            lru_len_reg <= lru_len_reg + CNT_BITS'(1);
        end
    end

    // free stack
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_depth_reg <= CNT_BITS'(POOL_FRAMES);
            for (int i = 0; i < POOL_FRAMES; i++)
                free_reg[i] <= FRAME_BITS'(POOL_FRAMES - 1 - i);
        end else if (cmd.op == OP_POP_FREE) begin
            free_depth_reg <= free_depth_reg - CNT_BITS'(1);
        end else if (cmd.op == OP_DELETE && free_depth_reg < CNT_BITS'(POOL_FRAMES)) begin
            free_reg[free_depth_reg[FRAME_BITS-1:0]] <= cmd.frame;
            free_depth_reg <= free_depth_reg + CNT_BITS'(1);
        end
    end

    // frame table
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_use_reg   <= '0;
            modified_reg <= '0;
            for (int i = 0; i < POOL_FRAMES; i++)
                pins_reg[i] <= '0;
        end else begin
            unique case (cmd.op)
                OP_INSTALL: begin
                    in_use_reg[cmd.frame]   <= 1'b1;
                    modified_reg[cmd.frame] <= 1'b0;
                    pins_reg[cmd.frame]     <= PIN_BITS'(1);
                end
                OP_PIN_INC: begin
                    if (pins_reg[cmd.frame] != '1)
                        pins_reg[cmd.frame] <= pins_reg[cmd.frame] + PIN_BITS'(1);
                end
                OP_UNPIN: begin
                    if (cmd.dirty)
                        modified_reg[cmd.frame] <= 1'b1;
                    if (pins_reg[cmd.frame] != '0)
                        pins_reg[cmd.frame] <= pin_dec;
                end
                OP_DELETE: begin
                    in_use_reg[cmd.frame]   <= 1'b0;
                    modified_reg[cmd.frame] <= 1'b0;
                end
                OP_CLEAN: modified_reg[cmd.frame] <= 1'b0;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_INSTALL)
            page_reg[cmd.frame] <= cmd.page;
    end

    // config registers and page allocation counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            icount_reg <= 16'd1;
            alloc_reg  <= '0;
        end else if (cfg_we) begin
            if (cfg_sel == REG_COUNT)
                icount_reg <= cfg_data;
            else
                alloc_reg <= PAGE_BITS'(cfg_data);
        end else if (cmd.alloc_step) begin
            alloc_reg <= PAGE_BITS'(alloc_reg + PAGE_BITS'(icount_reg));
        end
    end
endmodule
`default_nettype wire

// File: sv/pbfm_control.sv
`default_nettype none
module pbfm_control import pbfm_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             req_valid,
    output logic                  req_ready,
    input  wire logic [2:0]       req_kind,
    input  wire logic [PAGE_BITS-1:0] req_page,
    input  wire logic             req_dirty,
    output logic                  res_valid,
    input  wire logic             res_ready,
    output result_t               res,
    output dp_cmd_t               cmd,
    input  wire dp_status_t       stat
);
    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_DECIDE, S_LRU_SCAN, S_LRU_RM, S_TAKE, S_VICTIM,
        S_INSTALL, S_WALK, S_EMIT, S_FINAL
    } state_t;

    state_t state_reg, state_next;
    logic [2:0]             kind_reg;
    logic [PAGE_BITS-1:0]   page_reg, page_next;
    logic                   dirty_reg;
    logic [FRAME_BITS-1:0]  frame_reg, frame_next;
    logic [CNT_BITS-1:0]    walk_reg, walk_next;
    logic                   res_valid_reg, res_valid_next;
    result_t                res_reg, res_next;
    logic                   fin_reg, fin_next;   // pending response after an emitted command
    result_t                fin_res_reg, fin_res_next;

    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = res_valid_reg;
    assign res = res_reg;

    function automatic result_t mk(logic [1:0] c, logic [PAGE_BITS-1:0] p,
                                   logic [FRAME_BITS-1:0] f, logic [1:0] s, logic l);
        result_t r;
        r.command = c; r.result_page = p; r.frame_index = f; r.status = s; r.last_item = l;
        return r;
    endfunction

    // next-state and datapath command
    always_comb begin
        state_next = state_reg;
        page_next = page_reg;
        frame_next = frame_reg;
        walk_next = walk_reg;
        res_valid_next = res_valid_reg;
        res_next = res_reg;
        fin_next = fin_reg;
        fin_res_next = fin_res_reg;
        cmd.op = OP_NONE;
        cmd.frame = frame_reg;
        cmd.page = page_reg;
        cmd.dirty = dirty_reg;
        cmd.scan_clear = 1'b0;
        cmd.alloc_step = 1'b0;
        if (res_valid_reg && res_ready)
            res_valid_next = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (req_valid) begin
                    page_next = req_page;
                    cmd.scan_clear = 1'b1;
                    walk_next = '0;
                    case (req_kind) inside
                        KIND_FETCH, KIND_UNPIN, KIND_DELETE, KIND_FLUSH: state_next = S_SCAN;
                        KIND_NEW: state_next = S_TAKE;
                        KIND_FLUSH_ALL: state_next = S_WALK;
                        default: begin
                            res_next = mk(CMD_RESP, '0, '0, ST_OK, 1'b1);
                            state_next = S_FINAL;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                cmd.op = OP_SCAN_STEP;
                if (stat.scan_done) begin
                    cmd.op = OP_NONE;
                    frame_next = stat.scan_frame;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                cmd.frame = frame_reg;
                state_next = S_FINAL;
                if (!stat.scan_hit) begin
                    unique case (kind_reg)
                        KIND_FETCH: state_next = S_TAKE;
                        KIND_DELETE: res_next = mk(CMD_RESP, page_reg, '0, ST_OK, 1'b1);
                        default: res_next = mk(CMD_RESP, page_reg, '0, ST_NOT_RES, 1'b1);
                    endcase
                end else begin
                    unique case (kind_reg)
                        KIND_FETCH: begin
                            cmd.op = OP_PIN_INC;
                            cmd.scan_clear = 1'b1;
                            res_next = mk(CMD_RESP, page_reg, frame_reg, ST_OK, 1'b1);
                            state_next = S_LRU_SCAN;
                        end
                        KIND_UNPIN: begin
                            cmd.op = OP_UNPIN;
                            if (stat.f_pins == '0) begin
                                res_next = mk(CMD_RESP, page_reg, frame_reg, ST_NOT_RES, 1'b1);
                            end else begin
                                res_next = mk(CMD_RESP, page_reg, frame_reg, ST_OK, 1'b1);
                                if (stat.f_pins == PIN_BITS'(1)) begin
                                    cmd.scan_clear = 1'b1;
                                    state_next = S_LRU_SCAN;
                                end
                            end
                        end
                        KIND_DELETE: begin
                            if (stat.f_pins != '0) begin
                                res_next = mk(CMD_RESP, page_reg, frame_reg, ST_PINNED, 1'b1);
                            end else begin
                                cmd.op = OP_DELETE;
                                cmd.scan_clear = 1'b1;
                                fin_res_next = mk(CMD_RESP, page_reg, frame_reg, ST_OK, 1'b1);
                                fin_next = 1'b1;
                                res_next = mk(CMD_WRITE, page_reg, frame_reg, ST_OK, 1'b0);
                                state_next = stat.f_modified ? S_EMIT : S_LRU_SCAN;
                                if (!stat.f_modified) begin
                                    res_next = fin_res_next;
                                    fin_next = 1'b0;
                                end
                            end
                        end
                        default: begin
                            cmd.op = OP_CLEAN;
                            res_next = mk(CMD_WRITE, page_reg, frame_reg, ST_OK, 1'b0);
                            fin_res_next = mk(CMD_RESP, page_reg, frame_reg, ST_OK, 1'b1);
                            fin_next = 1'b1;
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end
            S_LRU_SCAN: begin
                cmd.op = OP_SCAN_STEP;
                if (stat.scan_done) begin
                    cmd.op = OP_NONE;
                    state_next = S_LRU_RM;
                end
            end
            S_LRU_RM: begin
                // unpin appends when absent; fetch and delete remove when present
                cmd.op = (kind_reg == KIND_UNPIN) ? OP_LRU_APPEND : OP_LRU_REMOVE;
                state_next = fin_reg ? S_EMIT : S_FINAL;
            end
            S_TAKE: begin
                if (stat.free_depth != '0) begin
                    cmd.op = OP_POP_FREE;
                    frame_next = stat.free_top;
                    state_next = S_INSTALL;
                end else if (stat.lru_length != '0) begin
                    cmd.op = OP_POP_LRU;
                    frame_next = stat.lru_head;
                    state_next = S_VICTIM;
                end else begin
                    res_next = mk(CMD_RESP, (kind_reg == KIND_NEW) ? '0 : page_reg, '0,
                                  ST_NO_FREE, 1'b1);
                    state_next = S_FINAL;
                end
            end
            S_VICTIM: begin
                cmd.op = OP_CLEAN;
                if (stat.f_in_use && stat.f_modified) begin
                    res_next = mk(CMD_WRITE, stat.f_page, frame_reg, ST_OK, 1'b0);
                    res_valid_next = 1'b1;
                end
                state_next = S_INSTALL;
            end
            S_INSTALL: begin
                if (!res_valid_reg) begin
                    cmd.op = OP_INSTALL;
                    if (kind_reg == KIND_NEW) begin
                        cmd.page = stat.alloc;
                        cmd.alloc_step = 1'b1;
                        page_next = stat.alloc;
                        res_next = mk(CMD_WRITE, stat.alloc, frame_reg, ST_OK, 1'b0);
                        fin_res_next = mk(CMD_RESP, stat.alloc, frame_reg, ST_OK, 1'b1);
                    end else begin
                        res_next = mk(CMD_READ, page_reg, frame_reg, ST_OK, 1'b0);
                        fin_res_next = mk(CMD_RESP, page_reg, frame_reg, ST_OK, 1'b1);
                    end
                    fin_next = 1'b1;
                    state_next = S_EMIT;
                end
            end
            S_WALK: begin
                // one frame per cycle, waits while a write is pending
                if (!res_valid_reg) begin
                    if (walk_reg == CNT_BITS'(POOL_FRAMES)) begin
                        res_next = mk(CMD_RESP, '0, '0, ST_OK, 1'b1);
                        state_next = S_FINAL;
                    end else begin
                        cmd.frame = walk_reg[FRAME_BITS-1:0];
                        walk_next = walk_reg + CNT_BITS'(1);
                        if (stat.f_in_use) begin
                            cmd.op = OP_CLEAN;
                            res_next = mk(CMD_WRITE, stat.f_page, walk_reg[FRAME_BITS-1:0],
                                          ST_OK, 1'b0);
                            res_valid_next = 1'b1;
                        end
                    end
                end
            end
            S_EMIT: begin
                if (!res_valid_reg) begin
                    res_valid_next = 1'b1;
                    if (fin_reg) begin
                        state_next = S_EMIT;
                    end else begin
                        state_next = S_IDLE;
                    end
                end else if (res_ready) begin
                    res_valid_next = fin_reg;
                    res_next = fin_res_reg;
                    fin_next = 1'b0;
                    if (!fin_reg) begin
                        state_next = S_IDLE;
                        res_valid_next = 1'b0;
                    end
                end
                if (fin_reg == 1'b0 && res_valid_reg && res_ready && res_reg.last_item)
                    state_next = S_IDLE;
                if (fin_reg == 1'b0 && res_valid_reg && !res_ready)
                    state_next = S_EMIT;
                if (fin_reg == 1'b0 && res_valid_reg && res_ready)
                    state_next = S_IDLE;
                if (!fin_reg && res_valid_reg && res_reg.last_item && res_ready) begin
                    res_valid_next = 1'b0;
                end
                if (!fin_reg && res_valid_reg && res_reg.last_item)
                    state_next = res_ready ? S_IDLE : S_EMIT;
                if (fin_reg && kind_reg == KIND_DELETE && !res_valid_reg)
                    state_next = S_EMIT;
            end
            S_FINAL: begin
                if (!res_valid_reg) begin
                    res_valid_next = 1'b1;
                    fin_next = 1'b0;
                    state_next = S_EMIT;
                end
            end
            default: state_next = S_IDLE;
        endcase
        // delete: after writing back, remove from LRU before the response
        if (state_reg == S_EMIT && kind_reg == KIND_DELETE && fin_reg &&
            res_valid_reg && res_ready) begin
            res_valid_next = 1'b0;
            state_next = S_LRU_SCAN;
            fin_next = 1'b0;
            res_next = fin_res_reg;
        end
        if (state_reg == S_LRU_RM && kind_reg == KIND_DELETE)
            state_next = S_FINAL;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            res_valid_reg <= 1'b0;
            fin_reg <= 1'b0;
            walk_reg <= '0;
        end else begin
            state_reg <= state_next;
            res_valid_reg <= res_valid_next;
            fin_reg <= fin_next;
            walk_reg <= walk_next;
        end
        page_reg <= page_next;
        frame_reg <= frame_next;
        res_reg <= res_next;
        fin_res_reg <= fin_res_next;
        if (state_reg == S_IDLE && req_valid) begin
            kind_reg <= req_kind;
            dirty_reg <= req_dirty;
        end
    end
endmodule
`default_nettype wire

// File: sv/page_buffer_frame_manager.sv
`default_nettype none
// Accept to final response: new takes a frame from the free stack; a fetch miss scans, then takes
// one; a fetch hit or an unpin reaching zero pins does a page walk of 16 frames plus an LRU walk;
// a delete with write-back emits the write before its LRU walk; a victim write comes before install.
// Flush-all visits each frame in turn and emits a write per resident frame, then the response.
// Throughput: one request at a time; the next is taken the cycle after the response leaves.
// Reset: aresetn synchronous active low; frames free, stack full with frame 0 on top,
// LRU empty, allocation counter zero, instance_count one.
module page_buffer_frame_manager import pbfm_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // tdata: page_number[30:0], mark_dirty[31]
    input  wire logic [31:0] s_tdata,
    // tuser: kind[2:0]
    input  wire logic [2:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // tdata: result_page[30:0], frame_index[34:31], status[36:35], zero fill
    output logic [39:0]      m_tdata,
    // tuser: command[1:0]
    output logic [1:0]       m_tuser,
    output logic             m_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    dp_cmd_t    cmd;
    dp_status_t stat;
    result_t    res;

    assign cfg_ready = 1'b1;

    pbfm_control u_ctrl (
        .aclk, .aresetn,
        .req_valid(s_tvalid), .req_ready(s_tready),
        .req_kind(s_tuser), .req_page(s_tdata[30:0]), .req_dirty(s_tdata[31]),
        .res_valid(m_tvalid), .res_ready(m_tready), .res,
        .cmd, .stat
    );

    pbfm_datapath u_dp (
        .aclk, .aresetn, .cmd,
        .cfg_we(cfg_valid), .cfg_sel(cfg_index[0]), .cfg_data,
        .stat
    );

    assign m_tdata = {3'b000, res.status, res.frame_index, res.result_page};
    assign m_tuser = res.command;
    assign m_tlast = res.last_item;
endmodule
`default_nettype wire

// File: sv/pbfm_checker.sv
`default_nettype none
module pbfm_sva import pbfm_pkg::*; (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        m_tlast
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped while stalled");
    a_last_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser == CMD_RESP)
        else $error("final transaction is not a response");
    a_cmd_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != CMD_RESP |-> m_tdata[36:35] == ST_OK && !m_tlast)
        else $error("disk command with status");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("accepted a request while busy");
endmodule

bind page_buffer_frame_manager pbfm_sva u_chk (.*);
`default_nettype wire
